[sv/ipv4fp_pkg.sv]
// ipv4fp_pkg: shared constants and types for the IPv4 fragment planner.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package ipv4fp_pkg;
	localparam int unsigned LEN_W         = 16;
	localparam int unsigned ID_W          = 16;
	localparam int unsigned NUM_W         = 7;
	localparam int unsigned OFS_W         = 13;
	localparam int unsigned HDR_BYTES     = 20;
	localparam int unsigned MTU_MIN       = 1044;
	localparam int unsigned MTU_RESET     = 1500;
	localparam int unsigned LEN_MIN       = 31;
	localparam int unsigned LEN_MAX       = 65534;
	localparam int unsigned MAX_FRAG_DEF  = 64;
	localparam int unsigned QUEUE_DEPTH   = 2;
	localparam int unsigned PADDR_W       = 3;
	localparam int unsigned PDATA_W       = 32;

	// register word index (paddr[2])
	localparam logic REG_MTU = 1'b0;

	// one classified datagram handed from front to back
	typedef struct packed {
		logic [LEN_W-1:0] rem;
		logic [LEN_W-1:0] chunk;
		logic [ID_W-1:0]  id;
	} desc_t;
endpackage
`default_nettype wire

[sv/ipv4fp_front.sv]
// ipv4fp_front: clamps the datagram length and derives the per-fragment chunk.
// Depends on ipv4fp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ipv4fp_front (
	input  wire logic [ipv4fp_pkg::LEN_W-1:0] datagram_length,
	input  wire logic [ipv4fp_pkg::ID_W-1:0]  datagram_id,
	input  wire logic [ipv4fp_pkg::LEN_W-1:0] mtu,
	output ipv4fp_pkg::desc_t                 desc
);
	import ipv4fp_pkg::*;

	logic [LEN_W-1:0] len_c;
	logic [LEN_W-1:0] mtu_c;
	logic [LEN_W-1:0] pay_c;

	always_comb begin
		if (datagram_length < LEN_W'(LEN_MIN)) begin
			len_c = LEN_W'(LEN_MIN);
		end else if (datagram_length > LEN_W'(LEN_MAX)) begin
			len_c = LEN_W'(LEN_MAX);
		end else begin
			len_c = datagram_length;
		end
		mtu_c = (mtu < LEN_W'(MTU_MIN)) ? LEN_W'(MTU_MIN) : mtu;
		pay_c = mtu_c - LEN_W'(HDR_BYTES);
		desc.rem   = len_c - LEN_W'(HDR_BYTES);
		// keep chunk a multiple of 8 so offsets line up with data sent
		desc.chunk = {pay_c[LEN_W-1:3], 3'b000};
		desc.id    = datagram_id;
	end
endmodule
`default_nettype wire

[sv/ipv4fp_queue.sv]
// ipv4fp_queue: short descriptor queue between front and back.
// Depends on ipv4fp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ipv4fp_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr_en,
	input  wire ipv4fp_pkg::desc_t  wr_desc,
	output logic                    full,
	input  wire logic               rd_en,
	output ipv4fp_pkg::desc_t       rd_desc,
	output logic                    valid
);
	import ipv4fp_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	desc_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign valid   = (count_q != '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && valid;
	assign rd_desc = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH)) else $error("queue count overflow");
	a_wr_grows: assert property (@(posedge clk) disable iff (!arst_n)
		do_wr && !do_rd |=> valid) else $error("queue lost a word");
	a_rd_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		do_rd && !do_wr |=> !full) else $error("queue still full after read");
endmodule
`default_nettype wire

[sv/ipv4fp_back.sv]
// ipv4fp_back: walks one descriptor fragment by fragment into an output register.
// Depends on ipv4fp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ipv4fp_back #(
	parameter int unsigned MAX_FRAGMENTS = ipv4fp_pkg::MAX_FRAG_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         q_valid,
	input  wire ipv4fp_pkg::desc_t            q_desc,
	output logic                              q_pop,
	output logic                              empty,
	input  wire logic                         pop,
	output logic [ipv4fp_pkg::NUM_W-1:0]      fragment_number,
	output logic [ipv4fp_pkg::ID_W-1:0]       fragment_id,
	output logic [ipv4fp_pkg::LEN_W-1:0]      payload_bytes,
	output logic [ipv4fp_pkg::OFS_W-1:0]      offset_units,
	output logic                              last
);
	import ipv4fp_pkg::*;

	localparam int unsigned NW = $clog2(MAX_FRAGMENTS + 1);

	logic             busy_q;
	logic [LEN_W-1:0] rem_q;
	logic [LEN_W-1:0] chunk_q;
	logic [LEN_W-1:0] sent_q;
	logic [ID_W-1:0]  id_q;
	logic [NW-1:0]    num_q;

	logic             ov_q;
	logic [NUM_W-1:0] o_num_q;
	logic [ID_W-1:0]  o_id_q;
	logic [LEN_W-1:0] o_pay_q;
	logic [OFS_W-1:0] o_ofs_q;
	logic             o_last_q;

	logic             produce;
	logic             fin_c;
	logic [LEN_W-1:0] pay_c;

	assign q_pop   = !busy_q && q_valid;
	assign produce = busy_q && (!ov_q || pop);

	always_comb begin
		// capped run: fragment MAX_FRAGMENTS takes whatever is left
		if (rem_q > chunk_q && num_q < NW'(MAX_FRAGMENTS)) begin
			pay_c = chunk_q;
			fin_c = 1'b0;
		end else begin
			pay_c = rem_q;
			fin_c = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ov_q   <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
			end else if (produce && fin_c) begin
				busy_q <= 1'b0;
			end
			if (produce) begin
				ov_q <= 1'b1;
			end else if (pop) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			rem_q   <= q_desc.rem;
			chunk_q <= q_desc.chunk;
			id_q    <= q_desc.id;
			sent_q  <= '0;
			num_q   <= NW'(1);
		end else if (produce) begin
			rem_q  <= rem_q - pay_c;
			sent_q <= sent_q + pay_c;
			num_q  <= num_q + 1'b1;
		end
		if (produce) begin
			o_num_q  <= NUM_W'(num_q);
			o_id_q   <= id_q;
			o_pay_q  <= pay_c;
			o_ofs_q  <= sent_q[LEN_W-1:3];
			o_last_q <= fin_c;
		end
	end

	assign empty           = !ov_q;
	assign fragment_number = o_num_q;
	assign fragment_id     = o_id_q;
	assign payload_bytes   = o_pay_q;
	assign offset_units    = o_ofs_q;
	assign last            = o_last_q;

	a_num_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !q_pop |-> num_q >= NW'(1) && num_q <= NW'(MAX_FRAGMENTS))
		else $error("fragment counter out of range");
	a_fin_ends: assert property (@(posedge clk) disable iff (!arst_n)
		produce && fin_c |=> !busy_q) else $error("run did not end on last word");
	a_more_stays: assert property (@(posedge clk) disable iff (!arst_n)
		produce && !fin_c |=> busy_q) else $error("run ended early");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !q_pop) else $error("descriptor taken mid-run");
endmodule
`default_nettype wire

[sv/ipv4_fragment_planner.sv]
// IPv4 fragment planner: one datagram word in, one word per fragment out.
// The first fragment passes the queue entry, the run registers and the output register.
// Throughput: the back end spends one descriptor load on each datagram, then
// gives one fragment a cycle while pop keeps up.
// A two-entry descriptor queue lets the input take words during a run.
// Reset: asynchronous, clears queue and run state; mtu returns to 1500.
`timescale 1ns / 1ps
`default_nettype none
module ipv4_fragment_planner #(
	parameter int unsigned MAX_FRAGMENTS = ipv4fp_pkg::MAX_FRAG_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [ipv4fp_pkg::PADDR_W-1:0] paddr,
	input  wire logic [ipv4fp_pkg::PDATA_W-1:0] pwdata,
	output logic      [ipv4fp_pkg::PDATA_W-1:0] prdata,
	output logic                                pready,
	input  wire logic                           push,
	output logic                                full,
	input  wire logic [ipv4fp_pkg::LEN_W-1:0]   datagram_length,
	input  wire logic [ipv4fp_pkg::ID_W-1:0]    datagram_id,
	output logic                                empty,
	input  wire logic                           pop,
	output logic      [ipv4fp_pkg::NUM_W-1:0]   fragment_number,
	output logic      [ipv4fp_pkg::ID_W-1:0]    fragment_id,
	output logic      [ipv4fp_pkg::LEN_W-1:0]   payload_bytes,
	output logic      [ipv4fp_pkg::OFS_W-1:0]   offset_units,
	output logic                                last
);
	import ipv4fp_pkg::*;

	logic [LEN_W-1:0] mtu_q;
	desc_t            f_desc;
	desc_t            q_desc;
	logic             q_valid;
	logic             q_pop;
	logic             q_full;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mtu_q <= LEN_W'(MTU_RESET);
		end else if (psel && penable && pwrite && paddr[2] == REG_MTU) begin
			mtu_q <= pwdata[LEN_W-1:0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MTU: prdata = {{(PDATA_W-LEN_W){1'b0}}, mtu_q};
			default: prdata = '0;
		endcase
	end

	ipv4fp_front u_front (
		.datagram_length (datagram_length),
		.datagram_id     (datagram_id),
		.mtu             (mtu_q),
		.desc            (f_desc)
	);

	ipv4fp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_desc (f_desc),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_desc (q_desc),
		.valid   (q_valid)
	);

	assign full = q_full;

	ipv4fp_back #(
		.MAX_FRAGMENTS (MAX_FRAGMENTS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_desc          (q_desc),
		.q_pop           (q_pop),
		.empty           (empty),
		.pop             (pop),
		.fragment_number (fragment_number),
		.fragment_id     (fragment_id),
		.payload_bytes   (payload_bytes),
		.offset_units    (offset_units),
		.last            (last)
	);
endmodule
`default_nettype wire

[sim/tb.sv]
// tb: self-checking bench for ipv4_fragment_planner, fragment plans predicted in-bench.
// Depends on ipv4fp_pkg (widths, limits) and the planner RTL; nothing else.
`timescale 1ns / 1ps
module tb;
	import ipv4fp_pkg::*;

	localparam int unsigned IDX_MTU     = 0;
	localparam int unsigned IDX_UNUSED  = 1;
	localparam int unsigned SETTLE      = 8;
	localparam int unsigned CYCLE_LIMIT = 1000000;

	typedef struct {
		logic [NUM_W-1:0] number;
		logic [ID_W-1:0]  id;
		logic [LEN_W-1:0] payload;
		logic [OFS_W-1:0] offset;
		logic             last;
	} fragment_t;

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [PDATA_W-1:0]   pwdata;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;
	logic                 push;
	logic                 full;
	logic [LEN_W-1:0]     datagram_length;
	logic [ID_W-1:0]      datagram_id;
	logic                 empty;
	logic                 pop;
	logic [NUM_W-1:0]     fragment_number;
	logic [ID_W-1:0]      fragment_id;
	logic [LEN_W-1:0]     payload_bytes;
	logic [OFS_W-1:0]     offset_units;
	logic                 last;

	fragment_t            frags_due[$];
	logic [15:0]          mtu_cfg;
	int unsigned          mismatch_count;
	int unsigned          cycle_count;
	int unsigned          send_idle_pct;
	int unsigned          recv_idle_pct;
	int unsigned          hold_cycles;

	ipv4_fragment_planner #(
		.MAX_FRAGMENTS(MAX_FRAG_DEF)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.push(push),
		.full(full),
		.datagram_length(datagram_length),
		.datagram_id(datagram_id),
		.empty(empty),
		.pop(pop),
		.fragment_number(fragment_number),
		.fragment_id(fragment_id),
		.payload_bytes(payload_bytes),
		.offset_units(offset_units),
		.last(last)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic int unsigned fragment_chunk();
		int unsigned m;
		m = (mtu_cfg < MTU_MIN) ? MTU_MIN : mtu_cfg;
		return ((m - HDR_BYTES) / 8) * 8;
	endfunction

	// expected fragments of one datagram, appended in send order
	function automatic void plan_fragments(logic [LEN_W-1:0] length, logic [ID_W-1:0] id);
		int unsigned len;
		int unsigned chunk;
		int unsigned remaining;
		int unsigned sent;
		int unsigned pay;
		logic        fin;
		fragment_t   f;
		len = length;
		if (len < LEN_MIN)
			len = LEN_MIN;
		if (len > LEN_MAX)
			len = LEN_MAX;
		chunk = fragment_chunk();
		remaining = len - HDR_BYTES;
		sent = 0;
		for (int k = 0; k < MAX_FRAG_DEF; k++) begin
			// cap: the last allowed fragment takes everything left
			if (remaining > chunk && k + 1 < MAX_FRAG_DEF) begin
				pay = chunk;
				fin = 1'b0;
			end else begin
				pay = remaining;
				fin = 1'b1;
			end
			f.number = NUM_W'(k + 1);
			f.id = id;
			f.payload = LEN_W'(pay);
			f.offset = OFS_W'(sent / 8);
			f.last = fin;
			frags_due.push_back(f);
			sent += pay;
			remaining -= pay;
			if (fin)
				break;
		end
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin : check_fragments
		fragment_t want;
		if (arst_n && pop && !empty) begin
			if (frags_due.size() == 0) begin
				$error("fragment word with nothing expected: number %0d id %0d",
					fragment_number, fragment_id);
				mismatch_count++;
			end else begin
				want = frags_due.pop_front();
				check_field("fragment_number", want.number, fragment_number);
				check_field("fragment_id", want.id, fragment_id);
				check_field("payload_bytes", want.payload, payload_bytes);
				check_field("offset_units", want.offset, offset_units);
				check_field("last", want.last, last);
			end
		end
	end

	// result side: random pop, or a held-off stretch when hold_cycles is set
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			pop = 1'b0;
		end else
			pop = ($urandom_range(99) >= recv_idle_pct);
	end

	// all driving tasks start and end just after a falling edge
	task automatic send_datagram(logic [LEN_W-1:0] length, logic [ID_W-1:0] id);
		while ($urandom_range(99) < send_idle_pct) begin
			push = 1'b0;
			@(negedge clk);
		end
		push = 1'b1;
		datagram_length = length;
		datagram_id = id;
		do
			@(posedge clk);
		while (full);
		plan_fragments(length, id);
		@(negedge clk);
		push = 1'b0;
	endtask

	task automatic wait_all_results();
		push = 1'b0;
		while (frags_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic config_write(int unsigned idx, logic [15:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = PADDR_W'(idx * 4);
		pwdata = {16'($urandom), value};
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (idx == IDX_MTU)
			mtu_cfg = value;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	function automatic logic [15:0] pick_mtu();
		case ($urandom_range(5))
			0: return 16'(MTU_MIN);
			1: return 16'hFFFF;
			2: return 16'($urandom);
			3: return 16'($urandom_range(0, MTU_MIN - 1));
			default: return 16'($urandom_range(MTU_MIN, 9000));
		endcase
	endfunction

	function automatic logic [LEN_W-1:0] pick_length();
		int unsigned v;
		case ($urandom_range(9))
			0: return LEN_W'($urandom_range(0, LEN_MIN - 1));
			1: return LEN_W'($urandom);
			2: return $urandom_range(1) ? 16'hFFFF : 16'(LEN_MAX);
			3, 4, 5: begin
				// land on or next to a whole number of fragments
				v = $urandom_range(1, 64) * fragment_chunk() + HDR_BYTES + $urandom_range(2) - 1;
				if (v > 16'hFFFF)
					v = $urandom_range(LEN_MIN, LEN_MAX);
				return LEN_W'(v);
			end
			6: return LEN_W'($urandom_range(LEN_MIN, 2000));
			default: return LEN_W'($urandom_range(LEN_MIN, LEN_MAX));
		endcase
	endfunction

	task automatic test_length_limits();
		send_datagram(16'd0, 16'h0000);
		send_datagram(16'd30, 16'hFFFF);
		send_datagram(16'(LEN_MIN), 16'h5A5A);
		send_datagram(16'd1500, 16'hA5A5);
		send_datagram(16'd1501, 16'h0001);
		send_datagram(16'd2980, 16'h8000);
		send_datagram(16'(LEN_MAX), 16'h7FFF);
		send_datagram(16'hFFFF, 16'h1234);
		wait_all_results();
	endtask

	task automatic test_mtu_settings();
		config_write(IDX_MTU, 16'(MTU_MIN));
		send_datagram(16'(LEN_MAX), 16'hFFFF);
		send_datagram(16'd1044, 16'h0000);
		send_datagram(16'd2068, 16'h00FF);
		wait_all_results();
		// below range, clamped to the minimum
		config_write(IDX_MTU, 16'd0);
		send_datagram(16'hFFFF, 16'hFF00);
		send_datagram(16'd1045, 16'h0F0F);
		wait_all_results();
		config_write(IDX_MTU, 16'(MTU_MIN - 1));
		send_datagram(16'd2069, 16'hF0F0);
		wait_all_results();
		config_write(IDX_MTU, 16'hFFFF);
		send_datagram(16'(LEN_MAX), 16'h3C3C);
		send_datagram(16'd65532, 16'hC3C3);
		send_datagram(16'd100, 16'h0002);
		wait_all_results();
		// MTU minus header not a multiple of 8
		config_write(IDX_MTU, 16'd1051);
		send_datagram(16'd2000, 16'h4444);
		wait_all_results();
		// write to an unmapped word must leave mtu alone
		config_write(IDX_UNUSED, 16'd1234);
		send_datagram(16'd3000, 16'h8888);
		wait_all_results();
	endtask

	task automatic test_stall_fill();
		config_write(IDX_MTU, 16'(MTU_RESET));
		hold_cycles = 600;
		for (int i = 0; i < 12; i++)
			send_datagram(LEN_W'($urandom_range(LEN_MIN, 6000)), ID_W'($urandom));
		wait_all_results();
	endtask

	task automatic test_random_traffic(int unsigned n, int unsigned sp, int unsigned rp);
		send_idle_pct = sp;
		recv_idle_pct = rp;
		for (int i = 0; i < n; i++) begin
			if (i % 36 == 0) begin
				wait_all_results();
				if (i % 72 == 36)
					config_write(IDX_UNUSED, 16'($urandom));
				config_write(IDX_MTU, pick_mtu());
			end
			send_datagram(pick_length(), ID_W'($urandom));
		end
		wait_all_results();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		push = 1'b0;
		pop = 1'b0;
		datagram_length = '0;
		datagram_id = '0;
		mtu_cfg = 16'(MTU_RESET);
		mismatch_count = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_cycles = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_length_limits();
		test_mtu_settings();
		test_stall_fill();
		test_random_traffic(107, 30, 66);
		test_random_traffic(107, 66, 30);
		test_random_traffic(106, 0, 0);

		push = 1'b0;
		while (frags_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

[files.f]
sv/ipv4fp_pkg.sv
sv/ipv4fp_front.sv
sv/ipv4fp_queue.sv
sv/ipv4fp_back.sv
sv/ipv4_fragment_planner.sv
sim/tb.sv
